// ===== sv/olc_pkg.sv =====
// Shared types and constants for the outcode line clipper.
// No dependencies; outcode_line_clipper refers to it by scoped names.
`default_nettype none

package olc_pkg;

  // Outcode bit positions
  localparam int unsigned OC_LEFT   = 0;
  localparam int unsigned OC_RIGHT  = 1;
  localparam int unsigned OC_TOP    = 2;
  localparam int unsigned OC_BOTTOM = 3;

  // Window register indexes on the configuration port
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOP    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOTTOM = 2'd3;

  // Edge moves before a segment is given up as rejected
  localparam int unsigned ITER_LIMIT = 16;
  localparam int unsigned ITER_BITS  = 5;

  typedef enum logic [1:0] {
    SIDE_BOTTOM,
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_LEFT
  } side_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_MUL,
    S_DIV
  } state_e;

endpackage

`default_nettype wire

// ===== sv/olc_serial_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Standalone; used by outcode_line_clipper.
`default_nettype none

module olc_serial_mul #(
  parameter int unsigned W = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           go_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic                fin_o,
  output logic [2*W-1:0]      prod_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0]  cnt_q, cnt_d;
  logic           run_q, run_d;
  logic           fin_q, fin_d;
  logic [2*W-1:0] acc_q, acc_d;
  logic [W-1:0]   mcand_q, mcand_d;
  logic [W:0]     sum;

  always_comb begin
    sum     = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
    cnt_d   = cnt_q;
    run_d   = run_q;
    fin_d   = 1'b0;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    if (go_i) begin
      acc_d   = {{W{1'b0}}, b_i};
      mcand_d = a_i;
      cnt_d   = CW'(W);
      run_d   = 1'b1;
    end else if (run_q) begin
      // add the multiplicand on a set low bit, then shift right
      acc_d = {sum, acc_q[W-1:1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
  end

  assign fin_o  = fin_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ===== sv/olc_serial_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; the quotient must fit in W bits (dividend high half below divisor).
`default_nettype none

module olc_serial_div #(
  parameter int unsigned W = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           go_i,
  input  wire logic [2*W-1:0] num_i,
  input  wire logic [W-1:0]   den_i,
  output logic                fin_o,
  output logic [W-1:0]        quo_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          fin_q, fin_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  den_q, den_d;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;

  always_comb begin
    shifted = {rem_q[W-1:0], quo_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    cnt_d   = cnt_q;
    run_d   = run_q;
    fin_d   = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (go_i) begin
      rem_d = {1'b0, num_i[2*W-1:W]};
      quo_d = num_i[W-1:0];
      den_d = den_i;
      cnt_d = CW'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      // subtract when it fits, shift the quotient bit in at the bottom
      if (!diff[W+1]) begin
        rem_d = diff[W:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign fin_o = fin_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ===== sv/outcode_line_clipper.sv =====
// Top level of the outcode line clipper: window registers, control sequencer, datapath.
// Depends on olc_pkg, olc_serial_mul and olc_serial_div.
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------------------------
//   request   start / busy       start_x_i, start_y_i, end_x_i, end_y_i
//   result    done_o strobe      accepted_o, clipped_{start,end}_{x,y}_o
//   config    cfg_we_i           cfg_idx_i (0 left, 1 top, 2 right, 3 bottom),
//                                cfg_data_i
//
// A request is taken when start is high and busy is low. Each edge move is an outcode
// test, a serial multiply and a serial divide; the multiplier and divider each work
// one bit per cycle. A segment needs up to four moves for an ordinary window and up
// to 16 moves for an inverted window.
// done_o is high for exactly one cycle; the receiver cannot stall, and busy drops in
// that same cycle so the next request may enter. Reset clears the window to zero.
`default_nettype none

module outcode_line_clipper #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // request
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [COORD_BITS-1:0]         start_x_i,
  input  wire logic signed [COORD_BITS-1:0]         start_y_i,
  input  wire logic signed [COORD_BITS-1:0]         end_x_i,
  input  wire logic signed [COORD_BITS-1:0]         end_y_i,
  // result
  output logic                                      done_o,
  output logic                                      accepted_o,
  output logic signed [COORD_BITS-1:0]              clipped_start_x_o,
  output logic signed [COORD_BITS-1:0]              clipped_start_y_o,
  output logic signed [COORD_BITS-1:0]              clipped_end_x_o,
  output logic signed [COORD_BITS-1:0]              clipped_end_y_o,
  // configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic [olc_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]                cfg_data_i
);

  localparam int unsigned W = COORD_BITS;

  // Outcode of one point against the window. Right is tested only when left is clear,
  // bottom only when top is clear.
  function automatic logic [3:0] outcode(
    input logic signed [W-1:0] x,
    input logic signed [W-1:0] y,
    input logic signed [W-1:0] wl,
    input logic signed [W-1:0] wt,
    input logic signed [W-1:0] wr,
    input logic signed [W-1:0] wb
  );
    logic [3:0] c;
    c = '0;
    if (x < wl) c[olc_pkg::OC_LEFT] = 1'b1;
    else if (x > wr) c[olc_pkg::OC_RIGHT] = 1'b1;
    if (y < wt) c[olc_pkg::OC_TOP] = 1'b1;
    else if (y > wb) c[olc_pkg::OC_BOTTOM] = 1'b1;
    return c;
  endfunction

  // Window registers
  logic signed [W-1:0] win_left_q, win_top_q, win_right_q, win_bottom_q;

  // Sequencer
  olc_pkg::state_e state_q, state_d;
  logic [olc_pkg::ITER_BITS-1:0] iter_q;

  // Working endpoints and per-move bookkeeping
  logic signed [W-1:0] sx_q, sy_q, ex_q, ey_q;
  olc_pkg::side_e side_q, side_d;
  logic           first_q, first_d;
  logic           neg_q, neg_d;
  logic [W-1:0]   den_q, den_d;

  // Result registers
  logic                done_q;
  logic                acc_res_q;
  logic signed [W-1:0] res_sx_q, res_sy_q, res_ex_q, res_ey_q;

  // Decision datapath
  logic [3:0]          c1, c2, co;
  logic                dec_accept, dec_reject, dec_move;
  logic                horiz;
  logic signed [W-1:0] edge_val;
  logic signed [W:0]   diff_a, diff_b, diff_d;
  logic [W:0]          mag_a, mag_b, mag_d;

  // Move application
  logic [W-1:0]        quo;
  logic [W-1:0]        quo_signed;
  logic signed [W-1:0] base, moved;

  // Sequencer outputs
  logic take_req, mul_go, div_go, apply_move;

  // Serial units
  logic           mul_fin, div_fin;
  logic [2*W-1:0] prod;

  // ---------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= '0;
      win_top_q    <= '0;
      win_right_q  <= '0;
      win_bottom_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        olc_pkg::CFG_LEFT:   win_left_q   <= cfg_data_i;
        olc_pkg::CFG_TOP:    win_top_q    <= cfg_data_i;
        olc_pkg::CFG_RIGHT:  win_right_q  <= cfg_data_i;
        olc_pkg::CFG_BOTTOM: win_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Outcode test and edge selection. The line parameter is always measured from the
  // first endpoint, whichever endpoint moves.
  always_comb begin
    c1 = outcode(sx_q, sy_q, win_left_q, win_top_q, win_right_q, win_bottom_q);
    c2 = outcode(ex_q, ey_q, win_left_q, win_top_q, win_right_q, win_bottom_q);
    co = (c1 != 4'b0) ? c1 : c2;

    dec_accept = (c1 | c2) == 4'b0;
    dec_reject = !dec_accept &&
                 (((c1 & c2) != 4'b0) ||
                  (iter_q == olc_pkg::ITER_BITS'(olc_pkg::ITER_LIMIT)));
    dec_move   = !dec_accept && !dec_reject;

    // bottom, top, right, left in that priority
    if (co[olc_pkg::OC_BOTTOM]) begin
      side_d   = olc_pkg::SIDE_BOTTOM;
      edge_val = win_bottom_q;
    end else if (co[olc_pkg::OC_TOP]) begin
      side_d   = olc_pkg::SIDE_TOP;
      edge_val = win_top_q;
    end else if (co[olc_pkg::OC_RIGHT]) begin
      side_d   = olc_pkg::SIDE_RIGHT;
      edge_val = win_right_q;
    end else begin
      side_d   = olc_pkg::SIDE_LEFT;
      edge_val = win_left_q;
    end
    horiz = (side_d == olc_pkg::SIDE_BOTTOM) || (side_d == olc_pkg::SIDE_TOP);

    if (horiz) begin
      diff_a = {ex_q[W-1], ex_q} - {sx_q[W-1], sx_q};
      diff_b = {edge_val[W-1], edge_val} - {sy_q[W-1], sy_q};
      diff_d = {ey_q[W-1], ey_q} - {sy_q[W-1], sy_q};
    end else begin
      diff_a = {ey_q[W-1], ey_q} - {sy_q[W-1], sy_q};
      diff_b = {edge_val[W-1], edge_val} - {sx_q[W-1], sx_q};
      diff_d = {ex_q[W-1], ex_q} - {sx_q[W-1], sx_q};
    end

    // differences of two in-range coordinates have magnitudes below 2^W
    mag_a = diff_a[W] ? -diff_a : diff_a;
    mag_b = diff_b[W] ? -diff_b : diff_b;
    mag_d = diff_d[W] ? -diff_d : diff_d;

    first_d = c1 != 4'b0;
    neg_d   = diff_a[W] ^ diff_b[W] ^ diff_d[W];
    den_d   = mag_d[W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      olc_pkg::S_IDLE: if (start) state_d = olc_pkg::S_TEST;
      olc_pkg::S_TEST: state_d = dec_move ? olc_pkg::S_MUL : olc_pkg::S_IDLE;
      olc_pkg::S_MUL:  if (mul_fin) state_d = olc_pkg::S_DIV;
      olc_pkg::S_DIV:  if (div_fin) state_d = olc_pkg::S_TEST;
      default:         state_d = olc_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    take_req   = 1'b0;
    mul_go     = 1'b0;
    div_go     = 1'b0;
    apply_move = 1'b0;
    unique case (state_q)
      olc_pkg::S_IDLE: take_req   = start;
      olc_pkg::S_TEST: mul_go     = dec_move;
      olc_pkg::S_MUL:  div_go     = mul_fin;
      olc_pkg::S_DIV:  apply_move = div_fin;
      default: ;
    endcase
  end

  assign busy = state_q != olc_pkg::S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olc_pkg::S_IDLE;
      iter_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == olc_pkg::S_TEST) && !dec_move;
      if (take_req) begin
        iter_q <= '0;
      end else if (apply_move) begin
        iter_q <= iter_q + olc_pkg::ITER_BITS'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Serial multiply of the two magnitudes, then divide by the third
  olc_serial_mul #(
    .W (W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (mag_a[W-1:0]),
    .b_i    (mag_b[W-1:0]),
    .fin_o  (mul_fin),
    .prod_o (prod)
  );

  olc_serial_div #(
    .W (W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (prod),
    .den_i  (den_q),
    .fin_o  (div_fin),
    .quo_o  (quo)
  );

  // Truncating quotient gets its sign back and is added to the first endpoint's
  // coordinate along the edge. Only an inverted window can overflow the quotient,
  // and such a window rejects every segment, so the wrapped value never shows.
  always_comb begin
    quo_signed = neg_q ? (~quo + W'(1)) : quo;
    if ((side_q == olc_pkg::SIDE_BOTTOM) || (side_q == olc_pkg::SIDE_TOP)) begin
      base = sx_q;
    end else begin
      base = sy_q;
    end
    moved = base + $signed(quo_signed);
  end

  // Endpoint and per-move registers (payload)
  always_ff @(posedge clk_i) begin
    if (take_req) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
    end else if (apply_move) begin
      unique case (side_q)
        olc_pkg::SIDE_BOTTOM: begin
          if (first_q) begin sx_q <= moved; sy_q <= win_bottom_q; end
          else begin ex_q <= moved; ey_q <= win_bottom_q; end
        end
        olc_pkg::SIDE_TOP: begin
          if (first_q) begin sx_q <= moved; sy_q <= win_top_q; end
          else begin ex_q <= moved; ey_q <= win_top_q; end
        end
        olc_pkg::SIDE_RIGHT: begin
          if (first_q) begin sx_q <= win_right_q; sy_q <= moved; end
          else begin ex_q <= win_right_q; ey_q <= moved; end
        end
        olc_pkg::SIDE_LEFT: begin
          if (first_q) begin sx_q <= win_left_q; sy_q <= moved; end
          else begin ex_q <= win_left_q; ey_q <= moved; end
        end
        default: ;
      endcase
    end

    if (mul_go) begin
      side_q  <= side_d;
      first_q <= first_d;
      neg_q   <= neg_d;
      den_q   <= den_d;
    end

    // Hold the result until the next decision; zeros on reject
    if ((state_q == olc_pkg::S_TEST) && !dec_move) begin
      acc_res_q <= dec_accept;
      res_sx_q  <= dec_accept ? sx_q : '0;
      res_sy_q  <= dec_accept ? sy_q : '0;
      res_ex_q  <= dec_accept ? ex_q : '0;
      res_ey_q  <= dec_accept ? ey_q : '0;
    end
  end

  assign done_o            = done_q;
  assign accepted_o        = acc_res_q;
  assign clipped_start_x_o = res_sx_q;
  assign clipped_start_y_o = res_sy_q;
  assign clipped_end_x_o   = res_ex_q;
  assign clipped_end_y_o   = res_ey_q;

  // ---------------------------------------------------------------------------
  // Assertions

  // A result only follows an outcode test
  a_done_after_test : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == olc_pkg::S_TEST))
    else $error("result strobe without a preceding outcode test");

  // The move counter never passes its limit
  a_iter_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= olc_pkg::ITER_BITS'(olc_pkg::ITER_LIMIT))
    else $error("edge move counter beyond its limit");

  // Rejected segments come out as all zeros
  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |->
      (clipped_start_x_o == '0) && (clipped_start_y_o == '0) &&
      (clipped_end_x_o == '0) && (clipped_end_y_o == '0))
    else $error("rejected segment with nonzero coordinates");

  // Accepted endpoints lie inside the window
  a_accept_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |->
      (clipped_start_x_o >= win_left_q) && (clipped_start_x_o <= win_right_q) &&
      (clipped_start_y_o >= win_top_q) && (clipped_start_y_o <= win_bottom_q) &&
      (clipped_end_x_o >= win_left_q) && (clipped_end_x_o <= win_right_q) &&
      (clipped_end_y_o >= win_top_q) && (clipped_end_y_o <= win_bottom_q))
    else $error("accepted segment endpoint outside the window");

endmodule

`default_nettype wire
